### rtl/core/pfa_pkg.sv
package pfa_pkg;

    localparam int FRAMES    = 65536;
    localparam int LEVELS    = 8;
    localparam int MAX_ORDER = 10;

    localparam int FRAME_W = 16;
    localparam int ORDER_W = 4;
    localparam int LVL_W   = 3;
    localparam int CODE_W  = 4;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 2;

    localparam int L1_DEPTH = FRAMES / 4;
    localparam int UP_DEPTH = FRAMES / 12 + 1;
    localparam int LEAF_AW  = $clog2(FRAMES);
    localparam int L1_AW    = $clog2(L1_DEPTH);
    localparam int UP_AW    = $clog2(UP_DEPTH);

    localparam logic [CODE_W-1:0] CODE_CAP = CODE_W'(MAX_ORDER + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

    // Memory selected by a tree level.
    localparam logic [1:0] MEM_LEAF  = 2'd0;
    localparam logic [1:0] MEM_L1    = 2'd1;
    localparam logic [1:0] MEM_UPPER = 2'd2;

    typedef struct packed {
        logic               action;
        logic [ORDER_W-1:0] order;
        logic [FRAME_W-1:0] frame;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] alloc_frame;
        logic [STAT_W-1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        WR_REQ,
        WR_ZERO,
        WR_CALC
    } t_wr_sel;

    typedef struct packed {
        logic               load;
        logic               scan_start;
        logic               idx_inc;
        logic               descend;
        logic               climb_up;
        logic               rd_en;
        logic               rd_child;
        logic [2:0]         k;
        logic               wr_en;
        t_wr_sel            wr_sel;
        logic               set_status;
        logic [STAT_W-1:0]  status;
        logic               clr_en;
        logic [FRAME_W-1:0] clr_addr;
        logic               out_load;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic is_free;
        logic count_zero;
        logic hit;
        logic scan_last;
        logic at_size;
        logic climb_more;
        logic changed;
    } t_sts;

    // Start of a level inside the packed upper map; levels two and up.
    function automatic logic [UP_AW-1:0] upper_off(input logic [LVL_W-1:0] lvl);
        logic [UP_AW-1:0] off;
        off = '0;
        for (int k = 2; k < LEVELS; k++) begin
            if (LVL_W'(k) < lvl) begin
                off = off + UP_AW'(FRAMES >> (2 * k));
            end
        end
        return off;
    endfunction

endpackage

### rtl/core/radix4_page_frame_allocator_unit.sv
// Page-frame allocator over a four-ary tree of availability codes.
// Request channel: i_in_valid / o_in_stall carry one beat per request
// (allocate or free, an even order and, for a free, the first frame).
// Result channel: o_out_valid / i_out_stall return exactly one beat per
// request: the allocated frame and a status code.
// Configuration: i_cfg_we writes top_level (index 0) or top_count (index 1);
// write only while no request is outstanding.
// After reset the block sweeps all three maps to full, one address a cycle,
// with o_in_stall high; configuration writes are taken.
// One request is worked on at a time, each map being a RAM with one read
// and one write port. A rejected request goes straight to its result. A
// free writes its code and then recomputes each parent level (four child
// reads and the old code read back to back, then a compare and write).
// An allocate first scans the top groups and descends, then writes likewise.
// The result sits in an output register, so a new request may be taken
// while the receiver stalls; the block then holds the next finished result
// internally until the output register is free.
module radix4_page_frame_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pfa_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pfa_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/core/pfa_ram.sv
module pfa_ram #(
    parameter int W = 1,
    parameter int D = 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pfa_dp.sv
module pfa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  pfa_pkg::t_in_item                 i_in_data,
    input  pfa_pkg::t_cmd                     i_cmd,
    output pfa_pkg::t_sts                     o_sts,
    output pfa_pkg::t_out_item                o_out_data
);
    import pfa_pkg::*;

    logic [LVL_W-1:0]   r_top_level;
    logic [COUNT_W-1:0] r_top_count;
    logic               r_action;
    logic [ORDER_W-1:0] r_order;
    logic [LVL_W-1:0]   r_lvl;
    logic [FRAME_W-1:0] r_idx;
    logic [FRAME_W-1:0] r_res_frame;
    logic [STAT_W-1:0]  r_status;
    t_out_item          r_out;
    logic               r_p_en;
    logic [2:0]         r_p_k;
    logic [1:0]         r_p_mem;
    logic               r_p_ok;
    logic [CODE_W-1:0]  r_slot [5];

    logic [LVL_W-1:0]   size;
    logic [CODE_W-1:0]  req;
    logic [LVL_W-1:0]   a_lvl;
    logic [FRAME_W-1:0] a_idx;
    logic [1:0]         a_mem;
    logic [4:0]         a_shamt;
    logic               a_ok;
    logic [1:0]         w_mem;
    logic [CODE_W-1:0]  w_val;
    logic [CODE_W-1:0]  q_val;
    logic [CODE_W-1:0]  child_free;
    logic [CODE_W:0]    full_code;
    logic [CODE_W-1:0]  best;
    logic               all_free;
    logic [CODE_W-1:0]  nv;
    logic [CODE_W-1:0]  nv_m;

    logic               leaf_we, l1_we, up_we;
    logic [LEAF_AW-1:0] leaf_wa, leaf_ra;
    logic [L1_AW-1:0]   l1_wa, l1_ra;
    logic [UP_AW-1:0]   up_wa, up_ra;
    logic [0:0]         leaf_wd, leaf_q;
    logic [1:0]         l1_wd, l1_q;
    logic [CODE_W-1:0]  up_wd, up_q;

    assign size = r_order[ORDER_W-1:1];
    assign req  = r_order + ORDER_W'(1);

    // Read address: either the current node or one of its four children.
    always_comb begin
        a_lvl   = i_cmd.rd_child ? r_lvl - LVL_W'(1) : r_lvl;
        a_idx   = i_cmd.rd_child ? {r_idx[FRAME_W-3:0], i_cmd.k[1:0]} : r_idx;
        a_mem   = (a_lvl == '0) ? MEM_LEAF : ((a_lvl == LVL_W'(1)) ? MEM_L1 : MEM_UPPER);
        a_shamt = 5'(FRAME_W) - {1'b0, a_lvl, 1'b0};
        a_ok    = (a_idx >> a_shamt) == '0;
        w_mem   = (r_lvl == '0) ? MEM_LEAF : ((r_lvl == LVL_W'(1)) ? MEM_L1 : MEM_UPPER);
    end

    always_comb begin
        case (r_p_mem)
            MEM_LEAF: q_val = {{(CODE_W-1){1'b0}}, leaf_q};
            MEM_L1:   q_val = {{(CODE_W-2){1'b0}}, l1_q};
            default:  q_val = up_q;
        endcase
        if (!r_p_ok) begin
            q_val = '0;
        end
    end

    // Recompute of a parent from its four children.
    always_comb begin
        child_free = {r_lvl, 1'b0} - CODE_W'(1);
        full_code  = {1'b0, r_lvl, 1'b0} + (CODE_W+1)'(1);
        best       = r_slot[0];
        all_free   = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (r_slot[i] > best) begin
                best = r_slot[i];
            end
            if (r_slot[i] != child_free) begin
                all_free = 1'b0;
            end
        end
        if (all_free) begin
            nv = (full_code > {1'b0, CODE_CAP}) ? CODE_CAP : full_code[CODE_W-1:0];
        end else begin
            nv = best;
        end
        nv_m = (r_lvl == LVL_W'(1)) ? (nv & CODE_W'(3)) : nv;
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_REQ:  w_val = req;
            WR_ZERO: w_val = '0;
            default: w_val = nv_m;
        endcase
        if (i_cmd.clr_en) begin
            w_val = '0;
        end
    end

    always_comb begin
        leaf_we = i_cmd.clr_en || (i_cmd.wr_en && w_mem == MEM_LEAF);
        l1_we   = (i_cmd.clr_en && {1'b0, i_cmd.clr_addr} < (FRAME_W+1)'(L1_DEPTH))
                  || (i_cmd.wr_en && w_mem == MEM_L1);
        up_we   = (i_cmd.clr_en && {1'b0, i_cmd.clr_addr} < (FRAME_W+1)'(UP_DEPTH))
                  || (i_cmd.wr_en && w_mem == MEM_UPPER);
        if (i_cmd.clr_en) begin
            leaf_wa = i_cmd.clr_addr[LEAF_AW-1:0];
            l1_wa   = i_cmd.clr_addr[L1_AW-1:0];
            up_wa   = i_cmd.clr_addr[UP_AW-1:0];
        end else begin
            leaf_wa = r_idx[LEAF_AW-1:0];
            l1_wa   = r_idx[L1_AW-1:0];
            up_wa   = upper_off(r_lvl) + r_idx[UP_AW-1:0];
        end
        leaf_wd = w_val[0:0];
        l1_wd   = w_val[1:0];
        up_wd   = w_val;
        leaf_ra = a_idx[LEAF_AW-1:0];
        l1_ra   = a_idx[L1_AW-1:0];
        up_ra   = upper_off(a_lvl) + a_idx[UP_AW-1:0];
    end

    pfa_ram #(.W(1), .D(FRAMES)) u_leaf (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_wa),
        .i_wdata (leaf_wd),
        .i_raddr (leaf_ra),
        .o_rdata (leaf_q)
    );

    pfa_ram #(.W(2), .D(L1_DEPTH)) u_l1 (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (l1_wa),
        .i_wdata (l1_wd),
        .i_raddr (l1_ra),
        .o_rdata (l1_q)
    );

    pfa_ram #(.W(CODE_W), .D(UP_DEPTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (up_we),
        .i_waddr (up_wa),
        .i_wdata (up_wd),
        .i_raddr (up_ra),
        .o_rdata (up_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_level <= LVL_W'(7);
            r_top_count <= COUNT_W'(4);
            r_p_en      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOP_LEVEL: r_top_level <= i_cfg_data[LVL_W-1:0];
                    CFG_TOP_COUNT: r_top_count <= i_cfg_data[COUNT_W-1:0];
                    default:       ;
                endcase
            end
            r_p_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_k   <= i_cmd.k;
        r_p_mem <= a_mem;
        r_p_ok  <= a_ok;
        if (r_p_en) begin
            case (r_p_k)
                3'd0:    r_slot[0] <= q_val;
                3'd1:    r_slot[1] <= q_val;
                3'd2:    r_slot[2] <= q_val;
                3'd3:    r_slot[3] <= q_val;
                default: r_slot[4] <= q_val;
            endcase
        end
        if (i_cmd.load) begin
            r_action    <= i_in_data.action;
            r_order     <= i_in_data.order;
            r_lvl       <= i_in_data.order[ORDER_W-1:1];
            r_idx       <= i_in_data.frame >> i_in_data.order;
            r_status    <= STATUS_DONE;
            r_res_frame <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_lvl <= r_top_level;
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + FRAME_W'(1);
            end else if (i_cmd.descend) begin
                r_lvl <= r_lvl - LVL_W'(1);
                r_idx <= {r_idx[FRAME_W-3:0], i_cmd.k[1:0]};
            end else if (i_cmd.climb_up) begin
                r_lvl <= r_lvl + LVL_W'(1);
                r_idx <= r_idx >> 2;
            end
            if (i_cmd.wr_en && i_cmd.wr_sel == WR_ZERO) begin
                r_res_frame <= r_idx << r_order;
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
        end
        if (i_cmd.out_load) begin
            r_out.alloc_frame <= r_res_frame;
            r_out.status      <= r_status;
        end
    end

    always_comb begin
        o_sts.reject     = r_order[0] || (r_order > ORDER_W'(MAX_ORDER))
                           || (size > r_top_level);
        o_sts.is_free    = r_action;
        o_sts.count_zero = r_top_count == '0;
        o_sts.hit        = q_val >= req;
        o_sts.scan_last  = r_idx[COUNT_W-1:0] == r_top_count - COUNT_W'(1);
        o_sts.at_size    = r_lvl == size;
        o_sts.climb_more = r_lvl < r_top_level;
        o_sts.changed    = nv_m != r_slot[4];
    end

    assign o_out_data = r_out;

endmodule

### rtl/core/pfa_ctrl.sv
module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  pfa_pkg::t_sts i_sts,
    output pfa_pkg::t_cmd o_cmd
);
    import pfa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DESC_NEXT,
        S_DESC_RD,
        S_DESC_EV,
        S_WRITE,
        S_CLIMB_RD,
        S_CLIMB_WAIT,
        S_CALC,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_k, n_k;
    logic [FRAME_W-1:0] r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    t_cmd               cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_k         = r_k;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        cmd.k       = r_k;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_en   = 1'b1;
                cmd.clr_addr = r_clr;
                n_clr        = r_clr + FRAME_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.reject) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_REJECT;
                    n_state        = S_DONE;
                end else if (i_sts.is_free) begin
                    n_state = S_WRITE;
                end else if (i_sts.count_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_NOFIT;
                    n_state        = S_DONE;
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (i_sts.hit) begin
                    n_state = S_DESC_NEXT;
                end else if (i_sts.scan_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_NOFIT;
                    n_state        = S_DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_DESC_NEXT: begin
                n_k = '0;
                if (i_sts.at_size) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DESC_RD;
                end
            end
            S_DESC_RD: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_child = 1'b1;
                n_state      = S_DESC_EV;
            end
            S_DESC_EV: begin
                if (i_sts.hit) begin
                    cmd.descend = 1'b1;
                    n_state     = S_DESC_NEXT;
                end else if (r_k == 3'd3) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STATUS_NOFIT;
                    n_state        = S_DONE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_DESC_RD;
                end
            end
            S_WRITE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = i_sts.is_free ? WR_REQ : WR_ZERO;
                n_k        = '0;
                if (i_sts.climb_more) begin
                    cmd.climb_up = 1'b1;
                    n_state      = S_CLIMB_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLIMB_RD: begin
                // Four children first, then the parent's own old code.
                cmd.rd_en    = 1'b1;
                cmd.rd_child = r_k != 3'd4;
                if (r_k == 3'd4) begin
                    n_state = S_CLIMB_WAIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_CLIMB_WAIT: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_CALC;
                n_k        = '0;
                if (i_sts.changed && i_sts.climb_more) begin
                    cmd.climb_up = 1'b1;
                    n_state      = S_CLIMB_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
